// ----- rtl/wav_header_check_rewrite_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef WAV_HEADER_CHECK_REWRITE_MACROS_SVH
`define WAV_HEADER_CHECK_REWRITE_MACROS_SVH

// Checked on every clock edge outside reset.
`define WHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("whc assertion failed");

// Checked on every clock edge, reset included.
`define WHC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("whc assertion failed");

`endif

// ----- rtl/whc_pkg.sv -----
// ----------------------------------------------------------------------------
// whc_pkg
// Types, constants and the header field table of the WAV header checker.
// ----------------------------------------------------------------------------
package whc_pkg;

  localparam logic [31:0] TAG_RIFF = 32'd1179011410;
  localparam logic [31:0] TAG_WAVE = 32'd1163280727;
  localparam logic [31:0] TAG_FMT  = 32'd544501094;
  localparam logic [31:0] TAG_DATA = 32'd1635017060;
  localparam logic [31:0] FIRST_DATA_POS = 32'd45;
  localparam logic [31:0] HDR_LAST_POS = FIRST_DATA_POS - 32'd1;

  localparam int NFIELDS = 13;
  localparam int JOB_BYTES = 40;
  localparam int JOB_W = JOB_BYTES * 8;
  localparam int CNT_W = $clog2(JOB_BYTES + 1);

  typedef logic [3:0] fld_idx_t;
  localparam fld_idx_t FLD_CHUNKID  = 4'd0;
  localparam fld_idx_t FLD_CHUNKSZ  = 4'd1;
  localparam fld_idx_t FLD_FORMTYPE = 4'd2;
  localparam fld_idx_t FLD_SUBID    = 4'd3;
  localparam fld_idx_t FLD_SUBSZ    = 4'd4;
  localparam fld_idx_t FLD_AUDFMT   = 4'd5;
  localparam fld_idx_t FLD_NCH      = 4'd6;
  localparam fld_idx_t FLD_SRATE    = 4'd7;
  localparam fld_idx_t FLD_BRATE    = 4'd8;
  localparam fld_idx_t FLD_BALIGN   = 4'd9;
  localparam fld_idx_t FLD_BPS      = 4'd10;
  localparam fld_idx_t FLD_DATAID   = 4'd11;
  localparam fld_idx_t FLD_DATASZ   = 4'd12;

  localparam logic [2:0] MODE_CHECK  = 3'd1;
  localparam logic [2:0] MODE_HALVE  = 3'd2;
  localparam logic [2:0] MODE_DOUBLE = 3'd3;
  localparam logic [2:0] MODE_MONO   = 3'd4;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_RIFF     = 4'd1;
  localparam logic [3:0] ST_WAVE     = 4'd2;
  localparam logic [3:0] ST_FMT      = 4'd3;
  localparam logic [3:0] ST_FMTSIZE  = 4'd4;
  localparam logic [3:0] ST_FORMAT   = 4'd5;
  localparam logic [3:0] ST_CHANNELS = 4'd6;
  localparam logic [3:0] ST_BYTERATE = 4'd7;
  localparam logic [3:0] ST_BITS     = 4'd8;
  localparam logic [3:0] ST_ALIGN    = 4'd9;
  localparam logic [3:0] ST_DATA     = 4'd10;
  localparam logic [3:0] ST_LONG     = 4'd11;
  localparam logic [3:0] ST_SHORT    = 4'd12;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       status_valid;
    logic [3:0] status;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    fld_idx_t   idx;
    logic [1:0] k;
    logic       last;
  } fld_loc_t;

  typedef struct packed {
    logic [JOB_W-1:0] data;
    logic [CNT_W-1:0] cnt;
    logic             eof;
    logic [3:0]       status;
  } job_t;

  function automatic fld_loc_t fld_locate(input logic [5:0] pos);
    fld_loc_t loc;
    loc = '0;
    case (pos) inside
      [6'd1:6'd4]: begin
        loc.idx = FLD_CHUNKID;  loc.k = 2'(pos - 6'd1);  loc.last = (pos == 6'd4);
      end
      [6'd5:6'd8]: begin
        loc.idx = FLD_CHUNKSZ;  loc.k = 2'(pos - 6'd5);  loc.last = (pos == 6'd8);
      end
      [6'd9:6'd12]: begin
        loc.idx = FLD_FORMTYPE; loc.k = 2'(pos - 6'd9);  loc.last = (pos == 6'd12);
      end
      [6'd13:6'd16]: begin
        loc.idx = FLD_SUBID;    loc.k = 2'(pos - 6'd13); loc.last = (pos == 6'd16);
      end
      [6'd17:6'd20]: begin
        loc.idx = FLD_SUBSZ;    loc.k = 2'(pos - 6'd17); loc.last = (pos == 6'd20);
      end
      [6'd21:6'd22]: begin
        loc.idx = FLD_AUDFMT;   loc.k = 2'(pos - 6'd21); loc.last = (pos == 6'd22);
      end
      [6'd23:6'd24]: begin
        loc.idx = FLD_NCH;      loc.k = 2'(pos - 6'd23); loc.last = (pos == 6'd24);
      end
      [6'd25:6'd28]: begin
        loc.idx = FLD_SRATE;    loc.k = 2'(pos - 6'd25); loc.last = (pos == 6'd28);
      end
      [6'd29:6'd32]: begin
        loc.idx = FLD_BRATE;    loc.k = 2'(pos - 6'd29); loc.last = (pos == 6'd32);
      end
      [6'd33:6'd34]: begin
        loc.idx = FLD_BALIGN;   loc.k = 2'(pos - 6'd33); loc.last = (pos == 6'd34);
      end
      [6'd35:6'd36]: begin
        loc.idx = FLD_BPS;      loc.k = 2'(pos - 6'd35); loc.last = (pos == 6'd36);
      end
      [6'd37:6'd40]: begin
        loc.idx = FLD_DATAID;   loc.k = 2'(pos - 6'd37); loc.last = (pos == 6'd40);
      end
      [6'd41:6'd44]: begin
        loc.idx = FLD_DATASZ;   loc.k = 2'(pos - 6'd41); loc.last = (pos == 6'd44);
      end
      default: begin
        loc = '0;
      end
    endcase
    return loc;
  endfunction

endpackage

// ----- rtl/wav_header_check_rewrite.sv -----
// ----------------------------------------------------------------------------
// wav_header_check_rewrite
// An accepted transaction is registered in the job stage, then loaded into the
// result queue stage. Throughput: one input transaction per cycle while neither
// stage is blocked; the result stage emits one result per cycle while out_ready
// is high, and the 40-byte mono header burst is the longest byte run of one input.
// Reset (rst_n low, synchronous) empties both stages and sets the mode to 1.
// ----------------------------------------------------------------------------
module wav_header_check_rewrite (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  whc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output whc_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata
);

  logic [2:0]  mode_r;
  logic [31:0] pos_r, pos_nxt, pos_upd;
  logic [31:0] hdr_r   [whc_pkg::NFIELDS];
  logic [31:0] hdr_nxt [whc_pkg::NFIELDS];
  logic [31:0] hdr_upd [whc_pkg::NFIELDS];

  logic               in_acc;
  logic [2:0]         m;
  logic               hdr_zone, data_zone;
  whc_pkg::fld_loc_t  loc;
  logic [1:0]         off2;
  logic [31:0]        dsz, w_sel;
  logic [47:0]        rate_prod;
  logic [28:0]        align_prod;
  logic [31:0]        len_m8;
  logic [3:0]         verdict;
  whc_pkg::job_t      job_new;

  logic           job_valid_r, job_valid_nxt;
  whc_pkg::job_t  job_r;

  logic [whc_pkg::JOB_W-1:0] b_data_r, b_data_nxt;
  logic [whc_pkg::CNT_W-1:0] b_cnt_r, b_cnt_nxt;
  logic                      b_eof_r, b_eof_nxt;
  logic [3:0]                b_status_r, b_status_nxt;
  logic                      b_valid, b_done, b_load, out_acc;

  assign in_acc = in_valid && in_ready;
  assign pos_upd = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;
  assign hdr_zone = (pos_upd <= whc_pkg::HDR_LAST_POS);
  assign loc = whc_pkg::fld_locate(pos_upd[5:0]);
  assign dsz = hdr_r[whc_pkg::FLD_DATASZ];
  assign data_zone = ({1'b0, pos_upd} <= ({1'b0, whc_pkg::HDR_LAST_POS} + {1'b0, dsz}));
  assign off2 = pos_upd[1:0] - whc_pkg::FIRST_DATA_POS[1:0];

  always_comb begin
    m = (mode_r inside {[whc_pkg::MODE_CHECK:whc_pkg::MODE_MONO]}) ? mode_r
                                                                    : whc_pkg::MODE_CHECK;
  end

  always_comb begin
    for (int f = 0; f < whc_pkg::NFIELDS; f++) begin
      for (int j = 0; j < 4; j++) begin
        hdr_upd[f][8*j +: 8] = hdr_r[f][8*j +: 8] |
          ((hdr_zone && loc.idx == 4'(f) && loc.k == 2'(j)) ? in_data.in_byte : 8'h00);
      end
      hdr_nxt[f] = (in_acc && in_data.end_of_file) ? 32'd0 :
                   (in_acc ? hdr_upd[f] : hdr_r[f]);
    end
    pos_nxt = in_acc ? (in_data.end_of_file ? 32'd0 : pos_upd) : pos_r;
  end

  assign rate_prod  = 48'(hdr_upd[whc_pkg::FLD_SRATE]) *
                      48'(hdr_upd[whc_pkg::FLD_BALIGN][15:0]);
  assign align_prod = 29'(hdr_upd[whc_pkg::FLD_BPS][15:3]) *
                      29'(hdr_upd[whc_pkg::FLD_NCH][15:0]);
  assign len_m8 = pos_upd - 32'd8;

  always_comb begin
    if (hdr_upd[whc_pkg::FLD_CHUNKID] != whc_pkg::TAG_RIFF) begin
      verdict = whc_pkg::ST_RIFF;
    end else if (hdr_upd[whc_pkg::FLD_FORMTYPE] != whc_pkg::TAG_WAVE) begin
      verdict = whc_pkg::ST_WAVE;
    end else if (hdr_upd[whc_pkg::FLD_SUBID] != whc_pkg::TAG_FMT) begin
      verdict = whc_pkg::ST_FMT;
    end else if (hdr_upd[whc_pkg::FLD_SUBSZ] != 32'd16) begin
      verdict = whc_pkg::ST_FMTSIZE;
    end else if (hdr_upd[whc_pkg::FLD_AUDFMT][15:0] != 16'd1) begin
      verdict = whc_pkg::ST_FORMAT;
    end else if (hdr_upd[whc_pkg::FLD_NCH][15:0] != 16'd1 &&
                 hdr_upd[whc_pkg::FLD_NCH][15:0] != 16'd2) begin
      verdict = whc_pkg::ST_CHANNELS;
    end else if (rate_prod != {16'd0, hdr_upd[whc_pkg::FLD_BRATE]}) begin
      verdict = whc_pkg::ST_BYTERATE;
    end else if (hdr_upd[whc_pkg::FLD_BPS][15:0] != 16'd8 &&
                 hdr_upd[whc_pkg::FLD_BPS][15:0] != 16'd16) begin
      verdict = whc_pkg::ST_BITS;
    end else if (align_prod != {13'd0, hdr_upd[whc_pkg::FLD_BALIGN][15:0]}) begin
      verdict = whc_pkg::ST_ALIGN;
    end else if (hdr_upd[whc_pkg::FLD_DATAID] != whc_pkg::TAG_DATA) begin
      verdict = whc_pkg::ST_DATA;
    end else if (pos_upd < 32'd8 || len_m8 < hdr_upd[whc_pkg::FLD_CHUNKSZ]) begin
      verdict = whc_pkg::ST_SHORT;
    end else if (len_m8 != hdr_upd[whc_pkg::FLD_CHUNKSZ]) begin
      verdict = whc_pkg::ST_LONG;
    end else begin
      verdict = whc_pkg::ST_OK;
    end
  end

  always_comb begin
    case (loc.idx)
      whc_pkg::FLD_SRATE: w_sel = (m == whc_pkg::MODE_HALVE) ?
                                  (hdr_upd[whc_pkg::FLD_SRATE] >> 1) :
                                  (hdr_upd[whc_pkg::FLD_SRATE] << 1);
      whc_pkg::FLD_BRATE: w_sel = (m == whc_pkg::MODE_HALVE) ?
                                  (hdr_upd[whc_pkg::FLD_BRATE] >> 1) :
                                  (hdr_upd[whc_pkg::FLD_BRATE] << 1);
      default:            w_sel = hdr_upd[whc_pkg::FLD_NCH];
    endcase
  end

  always_comb begin
    job_new = '0;
    job_new.eof = in_data.end_of_file;
    job_new.status = verdict;
    if (hdr_zone) begin
      if (m == whc_pkg::MODE_HALVE || m == whc_pkg::MODE_DOUBLE) begin
        if (loc.idx == whc_pkg::FLD_NCH || loc.idx == whc_pkg::FLD_SRATE ||
            loc.idx == whc_pkg::FLD_BRATE) begin
          if (loc.last) begin
            job_new.data[31:0] = w_sel;
            job_new.cnt = (loc.idx == whc_pkg::FLD_NCH) ? whc_pkg::CNT_W'(2)
                                                         : whc_pkg::CNT_W'(4);
          end
        end else begin
          job_new.data[7:0] = in_data.in_byte;
          job_new.cnt = whc_pkg::CNT_W'(1);
        end
      end else if (m == whc_pkg::MODE_MONO) begin
        if (loc.idx == whc_pkg::FLD_CHUNKID) begin
          job_new.data[7:0] = in_data.in_byte;
          job_new.cnt = whc_pkg::CNT_W'(1);
        end else if (pos_upd == whc_pkg::HDR_LAST_POS) begin
          job_new.data = {
            hdr_upd[whc_pkg::FLD_DATASZ] >> 1,
            hdr_upd[whc_pkg::FLD_DATAID],
            hdr_upd[whc_pkg::FLD_BPS][15:0],
            hdr_upd[whc_pkg::FLD_BALIGN][15:1] == 15'd0 ? 16'd0
              : {1'b0, hdr_upd[whc_pkg::FLD_BALIGN][15:1]},
            hdr_upd[whc_pkg::FLD_BRATE] >> 1,
            hdr_upd[whc_pkg::FLD_SRATE],
            16'd1,
            hdr_upd[whc_pkg::FLD_AUDFMT][15:0],
            hdr_upd[whc_pkg::FLD_SUBSZ],
            hdr_upd[whc_pkg::FLD_SUBID],
            hdr_upd[whc_pkg::FLD_FORMTYPE],
            hdr_upd[whc_pkg::FLD_CHUNKSZ] - hdr_upd[whc_pkg::FLD_DATASZ] +
              (hdr_upd[whc_pkg::FLD_DATASZ] >> 1)
          };
          job_new.cnt = whc_pkg::CNT_W'(whc_pkg::JOB_BYTES);
        end
      end
    end else if (data_zone) begin
      job_new.data[7:0] = in_data.in_byte;
      if (m == whc_pkg::MODE_HALVE || m == whc_pkg::MODE_DOUBLE) begin
        job_new.cnt = whc_pkg::CNT_W'(1);
      end else if (m == whc_pkg::MODE_MONO) begin
        if ((hdr_r[whc_pkg::FLD_BALIGN][15:0] == 16'd2 && !off2[0]) ||
            (hdr_r[whc_pkg::FLD_BALIGN][15:0] == 16'd4 && !off2[1])) begin
          job_new.cnt = whc_pkg::CNT_W'(1);
        end
      end
    end else if (m != whc_pkg::MODE_CHECK) begin
      job_new.data[7:0] = in_data.in_byte;
      job_new.cnt = whc_pkg::CNT_W'(1);
    end
  end

  assign b_valid = (b_cnt_r != '0) || b_eof_r;
  assign out_acc = out_valid && out_ready;
  assign b_done  = out_acc && out_data.last_of_run;
  assign b_load  = job_valid_r && (!b_valid || b_done);
  assign in_ready = !job_valid_r || !b_valid || b_done;

  always_comb begin
    job_valid_nxt = job_valid_r;
    if (in_acc) begin
      job_valid_nxt = (job_new.cnt != '0) || job_new.eof;
    end else if (b_load) begin
      job_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    b_data_nxt   = b_data_r;
    b_cnt_nxt    = b_cnt_r;
    b_eof_nxt    = b_eof_r;
    b_status_nxt = b_status_r;
    if (b_load) begin
      b_data_nxt   = job_r.data;
      b_cnt_nxt    = job_r.cnt;
      b_eof_nxt    = job_r.eof;
      b_status_nxt = job_r.status;
    end else if (out_acc) begin
      if (b_cnt_r != '0) begin
        b_data_nxt = b_data_r >> 8;
        b_cnt_nxt  = b_cnt_r - whc_pkg::CNT_W'(1);
      end else begin
        b_eof_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid = b_valid;
    out_data.has_byte     = (b_cnt_r != '0);
    out_data.out_byte     = (b_cnt_r != '0) ? b_data_r[7:0] : 8'h00;
    out_data.status_valid = (b_cnt_r == '0);
    out_data.status       = (b_cnt_r == '0) ? b_status_r : whc_pkg::ST_OK;
    out_data.last_of_run  = (b_cnt_r == '0) ||
                            (b_cnt_r == whc_pkg::CNT_W'(1) && !b_eof_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= whc_pkg::MODE_CHECK;
      pos_r       <= 32'd0;
      job_valid_r <= 1'b0;
      b_cnt_r     <= '0;
      b_eof_r     <= 1'b0;
      for (int f = 0; f < whc_pkg::NFIELDS; f++) begin
        hdr_r[f] <= 32'd0;
      end
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      pos_r       <= pos_nxt;
      job_valid_r <= job_valid_nxt;
      b_cnt_r     <= b_cnt_nxt;
      b_eof_r     <= b_eof_nxt;
      for (int f = 0; f < whc_pkg::NFIELDS; f++) begin
        hdr_r[f] <= hdr_nxt[f];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_r <= job_new;
    end
    b_data_r   <= b_data_nxt;
    b_status_r <= b_status_nxt;
  end

endmodule

// ----- rtl/whc_checker.sv -----
// ----------------------------------------------------------------------------
// whc_checker
// Port-level checks of the WAV header checker's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "wav_header_check_rewrite_macros.svh"

module whc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input whc_pkg::out_item_t  out_data
);

  // A reset leaves no result transaction pending.
  `WHC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

  // A stalled result transaction holds.
  `WHC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // Every result is either a byte or a verdict.
  `WHC_ASSERT(a_kind, out_valid |-> (out_data.has_byte ^ out_data.status_valid))

  // A verdict closes the run of its input and carries a defined code.
  `WHC_ASSERT(a_verdict, out_valid && out_data.status_valid |->
    out_data.last_of_run && out_data.status <= whc_pkg::ST_SHORT)

endmodule

bind wav_header_check_rewrite whc_checker u_whc_checker (.*);

// ----- dv/wav_header_check_rewrite_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_header_check_rewrite_tb
// Streams short directed files and then random WAV files, most of them with a
// well-formed canonical header, through the checker in every mode. A scoreboard
// predicts each byte and verdict and compares them with the result stream while
// both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module wav_header_check_rewrite_tb;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd0;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 130;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 30;

  class wav_scoreboard;
    whc_pkg::out_item_t expected_q[$];
    whc_pkg::out_item_t run_q[$];
    logic [2:0]  mode;
    logic [31:0] byte_pos;
    logic [31:0] fields [whc_pkg::NFIELDS];
    int          errors;

    function new();
      mode = whc_pkg::MODE_CHECK;
      errors = 0;
      clear_file();
    endfunction

    function void clear_file();
      byte_pos = '0;
      foreach (fields[i]) fields[i] = '0;
    endfunction

    function void set_mode(logic [2:0] m);
      mode = m;
    endfunction

    function int field_len(int f);
      return (f == whc_pkg::FLD_AUDFMT || f == whc_pkg::FLD_NCH ||
              f == whc_pkg::FLD_BALIGN || f == whc_pkg::FLD_BPS) ? 2 : 4;
    endfunction

    function void add_byte(logic [7:0] b);
      whc_pkg::out_item_t r;
      r = '0;
      r.out_byte = b;
      r.has_byte = 1'b1;
      run_q.push_back(r);
    endfunction

    function void add_word(logic [31:0] w, int len);
      for (int i = 0; i < len; i++) add_byte(w[8*i +: 8]);
    endfunction

    function void add_mono_header();
      logic [31:0] dsz;
      dsz = fields[whc_pkg::FLD_DATASZ];
      add_word(fields[whc_pkg::FLD_CHUNKSZ] - dsz + (dsz >> 1), 4);
      add_word(fields[whc_pkg::FLD_FORMTYPE], 4);
      add_word(fields[whc_pkg::FLD_SUBID], 4);
      add_word(fields[whc_pkg::FLD_SUBSZ], 4);
      add_word(fields[whc_pkg::FLD_AUDFMT], 2);
      add_word(32'd1, 2);
      add_word(fields[whc_pkg::FLD_SRATE], 4);
      add_word(fields[whc_pkg::FLD_BRATE] >> 1, 4);
      add_word(fields[whc_pkg::FLD_BALIGN] >> 1, 2);
      add_word(fields[whc_pkg::FLD_BPS], 2);
      add_word(fields[whc_pkg::FLD_DATAID], 4);
      add_word(dsz >> 1, 4);
    endfunction

    function logic [3:0] verdict();
      logic [63:0] prod;
      logic [63:0] align;
      prod = {32'd0, fields[whc_pkg::FLD_SRATE]} * {32'd0, fields[whc_pkg::FLD_BALIGN]};
      align = {32'd0, fields[whc_pkg::FLD_BPS] >> 3} * {32'd0, fields[whc_pkg::FLD_NCH]};
      if (fields[whc_pkg::FLD_CHUNKID] != whc_pkg::TAG_RIFF) return whc_pkg::ST_RIFF;
      if (fields[whc_pkg::FLD_FORMTYPE] != whc_pkg::TAG_WAVE) return whc_pkg::ST_WAVE;
      if (fields[whc_pkg::FLD_SUBID] != whc_pkg::TAG_FMT) return whc_pkg::ST_FMT;
      if (fields[whc_pkg::FLD_SUBSZ] != 32'd16) return whc_pkg::ST_FMTSIZE;
      if (fields[whc_pkg::FLD_AUDFMT] != 32'd1) return whc_pkg::ST_FORMAT;
      if (fields[whc_pkg::FLD_NCH] != 32'd1 && fields[whc_pkg::FLD_NCH] != 32'd2)
        return whc_pkg::ST_CHANNELS;
      if (prod != {32'd0, fields[whc_pkg::FLD_BRATE]}) return whc_pkg::ST_BYTERATE;
      if (fields[whc_pkg::FLD_BPS] != 32'd8 && fields[whc_pkg::FLD_BPS] != 32'd16)
        return whc_pkg::ST_BITS;
      if (align != {32'd0, fields[whc_pkg::FLD_BALIGN]}) return whc_pkg::ST_ALIGN;
      if (fields[whc_pkg::FLD_DATAID] != whc_pkg::TAG_DATA) return whc_pkg::ST_DATA;
      if (byte_pos < 32'd8 || byte_pos - 32'd8 < fields[whc_pkg::FLD_CHUNKSZ])
        return whc_pkg::ST_SHORT;
      if (byte_pos - 32'd8 != fields[whc_pkg::FLD_CHUNKSZ]) return whc_pkg::ST_LONG;
      return whc_pkg::ST_OK;
    endfunction

    function void note_input(whc_pkg::in_item_t it);
      logic [2:0]  m;
      logic [31:0] off;
      logic [31:0] al;
      logic [31:0] w;
      logic [63:0] data_end;
      whc_pkg::out_item_t v;
      int          f;
      int          s;
      int          len;
      int          k;
      bit          found;
      m = (mode >= whc_pkg::MODE_CHECK && mode <= whc_pkg::MODE_MONO) ? mode
                                                                       : whc_pkg::MODE_CHECK;
      run_q.delete();
      if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
      data_end = {32'd0, whc_pkg::HDR_LAST_POS} + {32'd0, fields[whc_pkg::FLD_DATASZ]};
      if (byte_pos <= whc_pkg::HDR_LAST_POS) begin
        found = 1'b0;
        s = 1;
        f = 0;
        k = 0;
        for (int i = 0; i < whc_pkg::NFIELDS && !found; i++) begin
          if (byte_pos >= s && byte_pos < s + field_len(i)) begin
            found = 1'b1;
            f = i;
            k = byte_pos - s;
          end else begin
            s += field_len(i);
          end
        end
        len = field_len(f);
        if (found) begin
          fields[f] = fields[f] | ({24'd0, it.in_byte} << (8 * k));
          if (m == whc_pkg::MODE_HALVE || m == whc_pkg::MODE_DOUBLE) begin
            if (f == whc_pkg::FLD_NCH || f == whc_pkg::FLD_SRATE ||
                f == whc_pkg::FLD_BRATE) begin
              if (k + 1 == len) begin
                w = fields[f];
                if (f != whc_pkg::FLD_NCH) w = (m == whc_pkg::MODE_HALVE) ? (w >> 1) : (w << 1);
                add_word(w, len);
              end
            end else begin
              add_byte(it.in_byte);
            end
          end else if (m == whc_pkg::MODE_MONO) begin
            if (f == whc_pkg::FLD_CHUNKID) add_byte(it.in_byte);
            else if (byte_pos == whc_pkg::HDR_LAST_POS) add_mono_header();
          end
        end
      end else if ({32'd0, byte_pos} <= data_end) begin
        off = byte_pos - whc_pkg::FIRST_DATA_POS;
        if (m == whc_pkg::MODE_HALVE || m == whc_pkg::MODE_DOUBLE) begin
          add_byte(it.in_byte);
        end else if (m == whc_pkg::MODE_MONO) begin
          al = fields[whc_pkg::FLD_BALIGN];
          if ((al == 32'd2 && !off[0]) || (al == 32'd4 && off[1:0] < 2'd2))
            add_byte(it.in_byte);
        end
      end else if (m != whc_pkg::MODE_CHECK) begin
        add_byte(it.in_byte);
      end
      if (it.end_of_file) begin
        v = '0;
        v.status_valid = 1'b1;
        v.status = verdict();
        run_q.push_back(v);
        clear_file();
      end
      if (run_q.size() > 0) begin
        v = run_q[run_q.size() - 1];
        v.last_of_run = 1'b1;
        run_q[run_q.size() - 1] = v;
      end
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got_v);
      if (want !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got_v);
      end
    endfunction

    function void check_result(whc_pkg::out_item_t got);
      whc_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual byte %0d status %0d",
                 $time, got.out_byte, got.status);
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
      compare_field("status_valid", 8'(want.status_valid), 8'(got.status_valid));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  whc_pkg::in_item_t  in_data;
  logic       out_valid;
  logic       out_ready = 1'b0;
  whc_pkg::out_item_t out_data;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  wav_scoreboard sb;
  logic [7:0]    file_q[$];
  int            sent_items = 0;
  int            results_seen = 0;
  int            cycles = 0;
  int            stall_cnt = 0;
  int            free_run = 0;
  bit            held = 1'b0;

  wav_header_check_rewrite dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  always @(posedge clk) begin
    logic nxt;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      nxt = 1'b1;
      if (stall_cnt > 0) begin
        stall_cnt--;
        nxt = 1'b0;
      end else if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        stall_cnt = HOLD_CYCLES - 1;
        nxt = 1'b0;
      end else if (free_run > 0) begin
        free_run--;
      end else if ($urandom_range(0, 49) == 0) begin
        free_run = $urandom_range(30, 60);
      end else begin
        stall_cnt = pick_gap();
        if (stall_cnt > 0) begin
          stall_cnt--;
          nxt = 1'b0;
        end
      end
      out_ready <= nxt;
    end
  end

  task automatic send_item(whc_pkg::in_item_t it, bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent_items++;
  endtask

  task automatic send_file(bit gaps);
    whc_pkg::in_item_t it;
    for (int i = 0; i < file_q.size(); i++) begin
      it.in_byte = file_q[i];
      it.end_of_file = (i == file_q.size() - 1);
      send_item(it, gaps);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [2:0] m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    sb.set_mode(m);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(logic [31:0] w, int len);
    for (int i = 0; i < len; i++) file_q.push_back(w[8*i +: 8]);
  endtask

  task automatic build_file();
    logic [31:0] hdr [whc_pkg::NFIELDS];
    logic [31:0] nch;
    logic [31:0] bps;
    logic [31:0] bal;
    logic [31:0] dsz;
    int          trail;
    int          cut;
    int          p;
    int          r;
    nch = $urandom_range(1, 2);
    bps = $urandom_range(0, 1) ? 32'd16 : 32'd8;
    bal = (bps >> 3) * nch;
    dsz = $urandom_range(0, 12);
    trail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    hdr[whc_pkg::FLD_CHUNKID]  = whc_pkg::TAG_RIFF;
    hdr[whc_pkg::FLD_CHUNKSZ]  = 32'd36 + dsz + trail;
    hdr[whc_pkg::FLD_FORMTYPE] = whc_pkg::TAG_WAVE;
    hdr[whc_pkg::FLD_SUBID]    = whc_pkg::TAG_FMT;
    hdr[whc_pkg::FLD_SUBSZ]    = 32'd16;
    hdr[whc_pkg::FLD_AUDFMT]   = 32'd1;
    hdr[whc_pkg::FLD_NCH]      = nch;
    hdr[whc_pkg::FLD_SRATE]    = $urandom >> 2;
    hdr[whc_pkg::FLD_BRATE]    = hdr[whc_pkg::FLD_SRATE] * bal;
    hdr[whc_pkg::FLD_BALIGN]   = bal;
    hdr[whc_pkg::FLD_BPS]      = bps;
    hdr[whc_pkg::FLD_DATAID]   = whc_pkg::TAG_DATA;
    hdr[whc_pkg::FLD_DATASZ]   = dsz;
    file_q.delete();
    for (int f = 0; f < whc_pkg::NFIELDS; f++) push_word(hdr[f], sb.field_len(f));
    repeat (dsz + trail) file_q.push_back(8'($urandom_range(0, 255)));
    r = $urandom_range(0, 9);
    if (r < 2) begin
      cut = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (r < 3) begin
      repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) begin
      p = $urandom_range(0, 43);
      if (p < file_q.size()) file_q[p] = 8'($urandom_range(0, 255));
    end
  endtask

  function logic [2:0] phase_mode(int ph);
    int r;
    case (ph)
      0: return whc_pkg::MODE_MONO;
      1: return whc_pkg::MODE_HALVE;
      2: return whc_pkg::MODE_DOUBLE;
      3: return MODE_UNUSED_LO;
      4: return MODE_UNUSED_HI;
      default: begin
        r = $urandom_range(0, 9);
        if (r < 3) return whc_pkg::MODE_MONO;
        if (r < 5) return whc_pkg::MODE_HALVE;
        if (r < 7) return whc_pkg::MODE_DOUBLE;
        if (r < 8) return whc_pkg::MODE_CHECK;
        return 3'($urandom_range(0, 7));
      end
    endcase
  endfunction

  initial begin
    int start_items;
    int phase;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = whc_pkg::MODE_CHECK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(whc_pkg::MODE_CHECK);
    file_q = '{8'hFF};
    send_file(1'b1);
    wait_idle();

    write_mode(MODE_UNUSED_LO);
    file_q = '{8'h52};
    send_file(1'b1);
    wait_idle();

    write_mode(MODE_UNUSED_HI);
    file_q = '{8'h52};
    send_file(1'b1);
    wait_idle();

    write_mode(whc_pkg::MODE_MONO);
    file_q.delete();
    push_word(whc_pkg::TAG_RIFF, 4);
    send_file(1'b1);
    wait_idle();

    write_mode(whc_pkg::MODE_HALVE);
    file_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_file(1'b0);
    wait_idle();

    write_mode(whc_pkg::MODE_DOUBLE);
    file_q.delete();
    push_word(whc_pkg::TAG_RIFF, 4);
    push_word(32'hFFFF_FFFF, 4);
    file_q.push_back(8'h80);
    send_file(1'b1);
    wait_idle();

    start_items = sent_items;
    phase = 0;
    while (sent_items - start_items < RANDOM_ITEMS || phase < 3) begin
      write_mode(phase_mode(phase));
      build_file();
      send_file($urandom_range(0, 3) != 0);
      wait_idle();
      phase++;
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
